// ===== hw/rtl/ternary_lane_dequantizer_core_assert.svh =====
// Assertion macros for the ternary lane dequantizer RTL.
`ifndef TERNARY_LANE_DEQUANTIZER_CORE_ASSERT_SVH
`define TERNARY_LANE_DEQUANTIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TLD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ternary lane dequantizer assertion failed");
`define TLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ternary lane dequantizer assertion failed");
`else
`define TLD_ASSERT_IMP(lbl, ante, cons)
`define TLD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/tld_pkg.sv =====
// Package with types, constants and float helpers for the ternary lane dequantizer.
package tld_pkg;

    localparam int unsigned LANE_TRITS  = 20;
    localparam int unsigned GROUPS      = 4;
    localparam logic [8:0]  GROUP_RADIX = 9'd243;
    localparam logic [31:0] RECIP_127   = 32'h3C010204;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC00000;
    localparam logic [31:0] QUIET_BIT   = 32'h00400000;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] groups;
        logic [4:0]  count;
    } tld_entry_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  top;
        logic [3:0]  k;
        logic [10:0] ms;
        logic [31:0] r;
        e = h[14:10];
        m = h[9:0];
        top = 4'd0;
        r = {h[15], 31'b0};
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                top = 4'(i);
            end
        end
        k = 4'd10 - top;
        ms = {1'b0, m} << k;
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                r = {h[15], 8'(8'd113 - {4'b0, k}), ms[9:0], 13'b0};
            end
        end else if (e == 5'd31) begin
            r = {h[15], 8'hFF, m, 13'b0};
            if (m != 10'd0) begin
                r = r | QUIET_BIT;
            end
        end else begin
            r = {h[15], 8'({3'b0, e} + 8'd112), m, 13'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] int8_to_single(input logic signed [7:0] v);
        logic [7:0]  mag;
        logic [2:0]  top;
        logic [23:0] ms;
        mag = v[7] ? 8'(-v) : v;
        top = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mag[i]) begin
                top = 3'(i);
            end
        end
        ms = {16'b0, mag} << (5'd23 - {2'b0, top});
        if (mag == 8'd0) begin
            return 32'd0;
        end
        return {v[7], 8'(8'd127 + {5'b0, top}), ms[22:0]};
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
        logic [47:0] p;
        logic        hi;
        logic [22:0] mant;
        logic        guard, sticky, rnd;
        logic [9:0]  e10;
        logic [30:0] body;
        logic [31:0] r;
        s = a[31] ^ b[31];
        nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        zero_a = (a[30:23] == 8'd0);
        zero_b = (b[30:23] == 8'd0);
        p = {24'b0, 1'b1, a[22:0]} * {24'b0, 1'b1, b[22:0]};
        hi = p[47];
        mant = hi ? p[46:24] : p[45:23];
        guard = hi ? p[23] : p[22];
        sticky = hi ? (|p[22:0]) : (|p[21:0]);
        e10 = {2'b0, a[30:23]} + {2'b0, b[30:23]} + {9'b0, hi} - 10'd127;
        rnd = guard && (sticky || mant[0]);
        body = {e10[7:0], mant} + {30'b0, rnd};
        if (nan_a) begin
            r = a | QUIET_BIT;
        end else if (nan_b) begin
            r = b | QUIET_BIT;
        end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
            r = DEFAULT_NAN;
        end else if (inf_a || inf_b) begin
            r = {s, 8'hFF, 23'b0};
        end else if (zero_a || zero_b) begin
            r = {s, 31'b0};
        end else begin
            r = {s, body};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ternary_lane_dequantizer_core.sv =====
// Top level of the ternary lane dequantizer.
// Each accepted lane word yields valid_count float words (20 at most, none for a
// count of zero), one per cycle while out_stall is low, with last set on the final
// one. The front part takes a new lane word only when idle, after the last one has
// been queued (a count of zero is never queued): its base-243 splitter works
// through eight bits of the word per cycle, while the lane scale is formed in two
// registered float multiplies. The back part emits one word per cycle unless
// out_stall holds it, and starts the next queued lane right after the last word of
// the current one.
module ternary_lane_dequantizer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       packed_word,
    input  logic [15:0]       page_scale_half,
    input  logic signed [7:0] lane_gain,
    input  logic [4:0]        valid_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       value_bits,
    output logic [4:0]        element_index,
    output logic              last
);
    import tld_pkg::*;

`include "ternary_lane_dequantizer_core_assert.svh"

    tld_entry_t push_data, pop_data;
    logic       q_push, q_full, q_pop, q_nonempty;

    tld_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packed_word    (packed_word),
        .page_scale_half(page_scale_half),
        .lane_gain      (lane_gain),
        .valid_count    (valid_count),
        .q_push         (q_push),
        .q_data         (push_data),
        .q_full         (q_full)
    );

    tld_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (pop_data),
        .nonempty(q_nonempty)
    );

    tld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (pop_data),
        .q_nonempty   (q_nonempty),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value_bits   (value_bits),
        .element_index(element_index),
        .last         (last)
    );

    `TLD_ASSERT_IMP(a_no_overflow, q_push, !q_full)
    `TLD_ASSERT_IMP(a_no_underflow, q_pop, q_nonempty)
    `TLD_ASSERT_IMP(a_last_at_end, out_valid && (element_index == 5'd19), last)
endmodule

// ===== hw/rtl/tld_front.sv =====
// Front part: takes a lane word, splits it into base-243 groups and forms the lane scale.
module tld_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         packed_word,
    input  logic [15:0]         page_scale_half,
    input  logic signed [7:0]   lane_gain,
    input  logic [4:0]          valid_count,
    output logic                q_push,
    output tld_pkg::tld_entry_t q_data,
    input  logic                q_full
);
    import tld_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        cnt_reg;
    logic [31:0]       w_reg, w_next;
    logic [7:0]        rem_reg, rem_next;
    logic [15:0]       half_reg;
    logic signed [7:0] ls_reg;
    logic [4:0]        count_reg;
    logic [31:0]       page_reg, frac_reg, scale_reg;
    logic [7:0]        grp_reg [GROUPS];
    logic [8:0]        trial;
    logic              accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        w_next = w_reg;
        rem_next = rem_reg;
        trial = 9'd0;
        for (int i = 0; i < 8; i++) begin
            trial = {rem_next, w_next[31]};
            w_next = {w_next[30:0], trial >= GROUP_RADIX};
            rem_next = (trial >= GROUP_RADIX) ? 8'(trial - GROUP_RADIX) : trial[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 4'd15) begin
                    state_next = (count_reg == 5'd0) ? S_IDLE : S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!q_full) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign q_push = (state_reg == S_PUSH) && !q_full;
    assign q_data = '{scale: scale_reg,
                      groups: {grp_reg[3], grp_reg[2], grp_reg[1], grp_reg[0]},
                      count: count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg <= 4'd0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cnt_reg <= 4'd0;
            end else if (state_reg == S_DIV) begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            w_reg <= packed_word;
            rem_reg <= 8'd0;
            half_reg <= page_scale_half;
            ls_reg <= lane_gain;
            count_reg <= (valid_count > 5'(LANE_TRITS)) ? 5'(LANE_TRITS) : valid_count;
        end else if (state_reg == S_DIV) begin
            w_reg <= w_next;
            if (cnt_reg[1:0] == 2'd3) begin
                grp_reg[cnt_reg[3:2]] <= rem_next;
                rem_reg <= 8'd0;
            end else begin
                rem_reg <= rem_next;
            end
            if (cnt_reg == 4'd0) begin
                page_reg <= half_to_single(half_reg);
                frac_reg <= fp32_mul(int8_to_single(ls_reg), RECIP_127);
            end
            if (cnt_reg == 4'd1) begin
                scale_reg <= fp32_mul(page_reg, frac_reg);
            end
        end
    end
endmodule

// ===== hw/rtl/tld_queue.sv =====
// Two-entry queue between the front and back parts.
module tld_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tld_pkg::tld_entry_t wr_data,
    output logic                full,
    input  logic                pop,
    output tld_pkg::tld_entry_t rd_data,
    output logic                nonempty
);
    import tld_pkg::*;

    tld_entry_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full = (fill_reg == 2'd2);
    assign nonempty = (fill_reg != 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

// ===== hw/rtl/tld_back.sv =====
// Back part: walks the trits of a queued lane and emits one scaled word per cycle while out_stall is low.
module tld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tld_pkg::tld_entry_t q_data,
    input  logic                q_nonempty,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         value_bits,
    output logic [4:0]          element_index,
    output logic                last
);
    import tld_pkg::*;

    logic        act_reg;
    tld_entry_t  ent_reg;
    logic [4:0]  j_reg;
    logic [1:0]  g_reg;
    logic [2:0]  d_reg;
    logic [7:0]  idx_reg;
    logic        ov_reg;
    logic [31:0] val_reg;
    logic [4:0]  eidx_reg;
    logic        last_reg;
    logic        adv, is_last;
    logic [7:0]  idx_cur, quo;
    logic [15:0] prod;
    logic [7:0]  rem8;
    logic [1:0]  trit;
    logic [31:0] sc, val;
    logic        sc_nan, sc_inf;

    assign adv = act_reg && (!ov_reg || !out_stall);
    assign is_last = ((j_reg + 5'd1) == ent_reg.count);
    assign q_pop = q_nonempty && (!act_reg || (adv && is_last));

    always_comb
    begin
        idx_cur = (d_reg == 3'd0) ? ent_reg.groups[{g_reg, 3'b0} +: 8] : idx_reg;
        prod = {8'b0, idx_cur} * 16'd171;
        quo = 8'(prod >> 9);
        rem8 = idx_cur - 8'(quo * 8'd3);
        trit = rem8[1:0];
        sc = ent_reg.scale;
        sc_nan = (sc[30:23] == 8'hFF) && (sc[22:0] != 23'd0);
        sc_inf = (sc[30:23] == 8'hFF) && (sc[22:0] == 23'd0);
        case (trit)
            2'd0:
            begin
                if (sc_nan) begin
                    val = sc;
                end else if (sc_inf) begin
                    val = DEFAULT_NAN;
                end else begin
                    val = {sc[31], 31'b0};
                end
            end
            2'd2:
            begin
                val = sc_nan ? sc : {!sc[31], sc[30:0]};
            end
            default:
            begin
                val = sc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            act_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                act_reg <= 1'b1;
            end else if (adv && is_last) begin
                act_reg <= 1'b0;
            end
            if (adv) begin
                ov_reg <= 1'b1;
            end else if (!out_stall) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            val_reg <= val;
            eidx_reg <= j_reg;
            last_reg <= is_last;
        end
        if (q_pop) begin
            ent_reg <= q_data;
            j_reg <= 5'd0;
            g_reg <= 2'd0;
            d_reg <= 3'd0;
        end else if (adv) begin
            idx_reg <= quo;
            j_reg <= j_reg + 5'd1;
            if (d_reg == 3'd4) begin
                d_reg <= 3'd0;
                g_reg <= g_reg + 2'd1;
            end else begin
                d_reg <= d_reg + 3'd1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign value_bits = val_reg;
    assign element_index = eidx_reg;
    assign last = last_reg;
endmodule
